/* sv/prsi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prsi_pkg
// Shared types and constants of the parallel range select indexer.
// ----------------------------------------------------------------------------
package prsi_pkg;

  localparam int LANES_DEF = 8;
  localparam int CHUNK_DEF = 32;
  localparam int MAX_LANES = 8;
  localparam int DATA_W    = 32;

  localparam logic [DATA_W-1:0] PAD_WORD    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] LOWER_RESET = 32'h8000_0000;
  localparam logic [DATA_W-1:0] UPPER_RESET = 32'h7FFF_FFFF;

  typedef enum logic [0:0] {
    CFG_LOWER = 1'b0,
    CFG_UPPER = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_READ,
    ST_LOAD,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic signed [31:0] value0;
    logic signed [31:0] value1;
    logic signed [31:0] value2;
    logic signed [31:0] value3;
    logic signed [31:0] value4;
    logic signed [31:0] value5;
    logic signed [31:0] value6;
    logic signed [31:0] value7;
    logic               final_line;
  } line_t;

  typedef struct packed {
    logic [31:0] index0;
    logic [31:0] index1;
    logic [31:0] index2;
    logic [31:0] index3;
    logic [31:0] index4;
    logic [31:0] index5;
    logic [31:0] index6;
    logic [31:0] index7;
    logic        is_status;
    logic        last_of_run;
  } result_t;

endpackage
`default_nettype wire

/* sv/prsi_lane_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prsi_lane_mem
// Match index buffer of one lane: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prsi_lane_mem #(
  parameter int DEPTH = prsi_pkg::CHUNK_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [prsi_pkg::DATA_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [prsi_pkg::DATA_W-1:0] rdata
);

  logic [prsi_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/prsi_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prsi_ctrl
// Fill counters, chunk sequencing, drain reads and the result register.
// ----------------------------------------------------------------------------
module prsi_ctrl #(
  parameter int LANES = prsi_pkg::LANES_DEF,
  parameter int CHUNK = prsi_pkg::CHUNK_DEF,
  localparam int AW = (CHUNK > 1) ? $clog2(CHUNK) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        line_valid,
  output logic                             line_stall,
  input  wire logic                        line_final,
  input  wire logic [LANES-1:0]            hit,
  output logic                             mem_we    [LANES],
  output logic      [AW-1:0]               mem_waddr [LANES],
  output logic      [prsi_pkg::DATA_W-1:0] mem_wdata [LANES],
  output logic                             mem_re,
  output logic      [AW-1:0]               mem_raddr,
  input  wire logic [prsi_pkg::DATA_W-1:0] mem_rdata [LANES],
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output prsi_pkg::result_t                result_data
);

  localparam int FW = $clog2(CHUNK + 1);
  localparam int SW = FW + 3;

  prsi_pkg::state_t state, state_next;

  logic [FW-1:0] fill [LANES];
  logic [FW-1:0] chunk_cnt;
  logic [FW-1:0] row;
  logic [FW-1:0] maxfill;
  logic [31:0]   next_index;
  logic [31:0]   match_total;
  logic [31:0]   index_total;
  logic          final_pend;
  logic          accept;
  logic          done;
  logic          out_free;
  logic          last_row;
  logic [FW-1:0] max_c;
  logic [SW-1:0] sum_c;
  logic [31:0]   word [prsi_pkg::MAX_LANES];
  prsi_pkg::result_t load_word;
  prsi_pkg::result_t status_word;

  assign line_stall = (state != prsi_pkg::ST_IDLE);
  assign accept     = line_valid && (state == prsi_pkg::ST_IDLE);
  assign done       = (chunk_cnt == FW'(CHUNK - 1)) || line_final;
  assign out_free   = !result_valid || !result_stall;
  assign last_row   = (FW'(row + 1'b1) == maxfill);
  assign mem_re     = (state == prsi_pkg::ST_READ) && out_free;
  assign mem_raddr  = row[AW-1:0];

  for (genvar p = 0; p < LANES; p++) begin : g_lane
    assign mem_we[p]    = accept && hit[p] && (fill[p] < FW'(CHUNK));
    assign mem_waddr[p] = fill[p][AW-1:0];
    assign mem_wdata[p] = next_index + 32'(p);
  end

  always_comb begin
    max_c = '0;
    sum_c = '0;
    for (int i = 0; i < LANES; i++) begin
      if (fill[i] > max_c) begin
        max_c = fill[i];
      end
      sum_c = sum_c + SW'(fill[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < prsi_pkg::MAX_LANES; i++) begin
      word[i] = prsi_pkg::PAD_WORD;
    end
    for (int i = 0; i < LANES; i++) begin
      if (row < fill[i]) begin
        word[i] = mem_rdata[i];
      end
    end
    load_word.index0      = word[0];
    load_word.index1      = word[1];
    load_word.index2      = word[2];
    load_word.index3      = word[3];
    load_word.index4      = word[4];
    load_word.index5      = word[5];
    load_word.index6      = word[6];
    load_word.index7      = word[7];
    load_word.is_status   = 1'b0;
    load_word.last_of_run = last_row && !final_pend;

    status_word             = '0;
    status_word.index0      = match_total;
    status_word.index1      = index_total;
    status_word.is_status   = 1'b1;
    status_word.last_of_run = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      prsi_pkg::ST_IDLE: begin
        if (accept && done) begin
          state_next = prsi_pkg::ST_SUM;
        end
      end
      prsi_pkg::ST_SUM: begin
        if (max_c != '0) begin
          state_next = prsi_pkg::ST_READ;
        end else if (final_pend) begin
          state_next = prsi_pkg::ST_STATUS;
        end else begin
          state_next = prsi_pkg::ST_IDLE;
        end
      end
      prsi_pkg::ST_READ: begin
        if (out_free) begin
          state_next = prsi_pkg::ST_LOAD;
        end
      end
      prsi_pkg::ST_LOAD: begin
        if (last_row) begin
          state_next = final_pend ? prsi_pkg::ST_STATUS : prsi_pkg::ST_IDLE;
        end else begin
          state_next = prsi_pkg::ST_READ;
        end
      end
      prsi_pkg::ST_STATUS: begin
        if (out_free) begin
          state_next = prsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prsi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        fill[i] <= '0;
      end
      chunk_cnt    <= '0;
      row          <= '0;
      maxfill      <= '0;
      next_index   <= '0;
      match_total  <= '0;
      index_total  <= '0;
      final_pend   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        prsi_pkg::ST_IDLE: begin
          if (accept) begin
            for (int i = 0; i < LANES; i++) begin
              if (mem_we[i]) begin
                fill[i] <= fill[i] + 1'b1;
              end
            end
            next_index <= next_index + 32'(LANES);
            chunk_cnt  <= done ? '0 : chunk_cnt + 1'b1;
            final_pend <= line_final;
          end
        end
        prsi_pkg::ST_SUM: begin
          maxfill     <= max_c;
          row         <= '0;
          match_total <= match_total + 32'(sum_c);
          index_total <= index_total + 32'(max_c);
          if (max_c == '0) begin
            for (int i = 0; i < LANES; i++) begin
              fill[i] <= '0;
            end
          end
        end
        prsi_pkg::ST_READ: begin
        end
        prsi_pkg::ST_LOAD: begin
          result_valid <= 1'b1;
          row          <= row + 1'b1;
          if (last_row) begin
            for (int i = 0; i < LANES; i++) begin
              fill[i] <= '0;
            end
          end
        end
        prsi_pkg::ST_STATUS: begin
          if (out_free) begin
            result_valid <= 1'b1;
            next_index   <= '0;
            match_total  <= '0;
            index_total  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == prsi_pkg::ST_LOAD) begin
      result_data <= load_word;
    end else if ((state == prsi_pkg::ST_STATUS) && out_free) begin
      result_data <= status_word;
    end
  end

endmodule
`default_nettype wire

/* sv/parallel_range_select_indexer_top.sv */
// A line that closes a chunk passes the sum, read and load states before index lines show.
// Throughput: 1 line per cycle inside a chunk; the drain stalls the input for a sum step,
// a registered lane memory read and a result load per index line, and a final line's status.
// Reset: synchronous; clears counters and fill counts and opens the bounds to the full
// signed range; lane memories are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_range_select_indexer_top
// Filters lines of signed lane values against exclusive bounds and emits the
// element indices of the matches per chunk, and a status line after a final line.
// ----------------------------------------------------------------------------
module parallel_range_select_indexer_top #(
  parameter int LANES = prsi_pkg::LANES_DEF,
  parameter int CHUNK = prsi_pkg::CHUNK_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [prsi_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                        line_valid,
  output logic                             line_stall,
  input  wire prsi_pkg::line_t             line_data,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output prsi_pkg::result_t                result_data
);

  localparam int AW = (CHUNK > 1) ? $clog2(CHUNK) : 1;

  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic signed [31:0] vals [prsi_pkg::MAX_LANES];
  logic [LANES-1:0]   hit;

  logic                        mem_we    [LANES];
  logic [AW-1:0]               mem_waddr [LANES];
  logic [prsi_pkg::DATA_W-1:0] mem_wdata [LANES];
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [prsi_pkg::DATA_W-1:0] mem_rdata [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= prsi_pkg::LOWER_RESET;
      upper_bound <= prsi_pkg::UPPER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prsi_pkg::CFG_LOWER: lower_bound <= cfg_data;
        prsi_pkg::CFG_UPPER: upper_bound <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign vals[0] = line_data.value0;
  assign vals[1] = line_data.value1;
  assign vals[2] = line_data.value2;
  assign vals[3] = line_data.value3;
  assign vals[4] = line_data.value4;
  assign vals[5] = line_data.value5;
  assign vals[6] = line_data.value6;
  assign vals[7] = line_data.value7;

  for (genvar p = 0; p < LANES; p++) begin : g_lane
    assign hit[p] = (vals[p] > lower_bound) && (vals[p] < upper_bound);

    prsi_lane_mem #(
      .DEPTH (CHUNK)
    ) u_mem (
      .clk   (clk),
      .we    (mem_we[p]),
      .waddr (mem_waddr[p]),
      .wdata (mem_wdata[p]),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata[p])
    );
  end

  prsi_ctrl #(
    .LANES (LANES),
    .CHUNK (CHUNK)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .line_valid   (line_valid),
    .line_stall   (line_stall),
    .line_final   (line_data.final_line),
    .hit          (hit),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
`default_nettype wire

/* sv/prsi_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prsi_checker
// Port-level checks of the indexer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module prsi_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              line_valid,
  input wire logic              line_stall,
  input wire prsi_pkg::line_t   line_data,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire prsi_pkg::result_t result_data
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result changed");

  // The status line always closes the run of results of its line.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.is_status |-> result_data.last_of_run)
    else $error("status line not marked last");

  // Only the two totals are carried on the status line.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.is_status |->
      result_data.index2 == '0 && result_data.index3 == '0 &&
      result_data.index4 == '0 && result_data.index5 == '0 &&
      result_data.index6 == '0 && result_data.index7 == '0)
    else $error("status line has nonzero upper fields");

  // A final line always starts a drain, so the next line waits.
  assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_stall && line_data.final_line |=> line_stall)
    else $error("line accepted right after a final line");

endmodule

bind parallel_range_select_indexer_top prsi_checker u_prsi_checker (.*);
`default_nettype wire
